// ----- hw/rtl/stt_pkg.sv -----
// Shared types, token codes and character helpers for the source tokenizer.
// No dependencies; imported by the scanner core, the result queue and the top level.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int SPAN_W = 24;

    // token kinds
    localparam logic [5:0] K_PLUS      = 6'd0;
    localparam logic [5:0] K_MINUS     = 6'd1;
    localparam logic [5:0] K_ARROW     = 6'd2;
    localparam logic [5:0] K_STAR      = 6'd3;
    localparam logic [5:0] K_SLASH     = 6'd4;
    localparam logic [5:0] K_PERCENT   = 6'd5;
    localparam logic [5:0] K_EQUAL     = 6'd6;
    localparam logic [5:0] K_EQ_EQ     = 6'd7;
    localparam logic [5:0] K_BANG_EQ   = 6'd8;
    localparam logic [5:0] K_LESS      = 6'd9;
    localparam logic [5:0] K_LESS_EQ   = 6'd10;
    localparam logic [5:0] K_GREATER   = 6'd11;
    localparam logic [5:0] K_GREATER_EQ = 6'd12;
    localparam logic [5:0] K_LPAREN    = 6'd13;
    localparam logic [5:0] K_RPAREN    = 6'd14;
    localparam logic [5:0] K_LBRACE    = 6'd15;
    localparam logic [5:0] K_RBRACE    = 6'd16;
    localparam logic [5:0] K_COMMA     = 6'd17;
    localparam logic [5:0] K_COLON     = 6'd18;
    localparam logic [5:0] K_SEMI      = 6'd19;
    localparam logic [5:0] K_IDENT     = 6'd20;
    localparam logic [5:0] K_KW_FIRST  = 6'd21;
    localparam logic [5:0] K_INT       = 6'd35;
    localparam logic [5:0] K_F32       = 6'd36;
    localparam logic [5:0] K_F64       = 6'd37;
    localparam logic [5:0] K_END       = 6'd38;

    // error codes
    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_UNEXP    = 3'd1;
    localparam logic [2:0] E_NONASCII = 3'd2;
    localparam logic [2:0] E_BADNUM   = 3'd3;
    localparam logic [2:0] E_LEADZ    = 3'd4;
    localparam logic [2:0] E_TOOLONG  = 3'd5;

    // number flag bits
    localparam int NF_FIRST_ZERO = 0;
    localparam int NF_MULTI      = 1;
    localparam int NF_LEADZ      = 2;
    localparam int NF_DOT        = 3;
    localparam int NF_BAD        = 4;
    localparam int NF_FRAC_DIGIT = 5;
    localparam int NF_TRAIL_F    = 6;

    localparam int NUM_KW = 14;

    // keywords, first character in the lowest byte
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        48'h0000_0000_6E66, 48'h0000_0074_656C, 48'h6E72_7574_6572, 48'h0000_0000_6669,
        48'h0000_6573_6C65, 48'h0065_6C69_6877, 48'h0000_6575_7274, 48'h0065_736C_6166,
        48'h0000_0034_3669, 48'h0000_0034_3666, 48'h0000_0032_3366, 48'h0000_6C6F_6F62,
        48'h0000_6469_6F76, 48'h6E72_6574_7865
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd2, 3'd3, 3'd6, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd6
    };

    typedef struct packed {
        logic [5:0]        kind;
        logic              is_end;
        logic [SPAN_W-1:0] span_b;
        logic [SPAN_W-1:0] span_e;
        logic              is_err;
        logic [2:0]        err;
        logic              last;
        logic              done;
    } res_t;

    typedef struct packed {
        logic [1:0]     n;
        res_t [2:0]     item;
    } push_t;

    typedef struct packed {
        logic [2:0] count;
    } qstat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return is_letter(c) || c == "_";
    endfunction

    function automatic logic [5:0] classify_word(input logic [47:0] buf_w,
                                                 input logic [2:0] len,
                                                 input logic too_long);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = 0; i < NUM_KW; i++) begin
            if (!too_long && KW_LEN[i] == len && KW_TEXT[i] == buf_w) begin
                k = 6'(int'(K_KW_FIRST) + i);
            end
        end
        return k;
    endfunction

    function automatic logic [7:0] number_add(input logic [7:0] fin, input logic [7:0] c);
        logic [7:0] f;
        f = fin;
        if (!f[NF_MULTI] && f[NF_FIRST_ZERO] && is_digit(c)) f[NF_LEADZ] = 1'b1;
        f[NF_MULTI] = 1'b1;
        if (!f[NF_DOT]) begin
            if (c == ".") f[NF_DOT] = 1'b1;
            else if (!is_digit(c)) f[NF_BAD] = 1'b1;
        end else if (f[NF_TRAIL_F]) begin
            f[NF_BAD] = 1'b1;
        end else if (is_digit(c)) begin
            f[NF_FRAC_DIGIT] = 1'b1;
        end else if (c == "f") begin
            f[NF_TRAIL_F] = 1'b1;
        end else begin
            f[NF_BAD] = 1'b1;
        end
        return f;
    endfunction

    // {error code, kind} of a finished number
    function automatic logic [8:0] finish_number(input logic [7:0] f);
        if (f[NF_LEADZ]) return {E_LEADZ, 6'd0};
        if (f[NF_DOT]) begin
            if (f[NF_BAD] || !f[NF_FRAC_DIGIT]) return {E_BADNUM, 6'd0};
            return {E_NONE, (f[NF_TRAIL_F] ? K_F32 : K_F64)};
        end
        if (f[NF_BAD] || (f[NF_FIRST_ZERO] && f[NF_MULTI])) return {E_BADNUM, 6'd0};
        return {E_NONE, K_INT};
    endfunction

endpackage

// ----- hw/rtl/stt_scan_core.sv -----
// Scanner state and per-byte token logic of the source tokenizer.
// Depends on stt_pkg; produces up to three results per accepted beat.
`timescale 1ns / 1ps

module stt_scan_core
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = 24
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] text_byte,
    input  logic       has_byte,
    input  logic       end_of_source,
    output push_t      push
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_IDENT   = 4'd1;
    localparam logic [3:0] M_NUMBER  = 4'd2;
    localparam logic [3:0] M_COMMENT = 4'd3;
    localparam logic [3:0] M_MINUS   = 4'd4;
    localparam logic [3:0] M_SLASH   = 4'd5;
    localparam logic [3:0] M_EQ      = 4'd6;
    localparam logic [3:0] M_BANG    = 4'd7;
    localparam logic [3:0] M_LT      = 4'd8;
    localparam logic [3:0] M_GT      = 4'd9;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

    logic [3:0]             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [OFFSET_BITS-1:0] tstart_reg, tstart_next;
    logic [47:0]            word_reg, word_next;
    logic [2:0]             wlen_reg, wlen_next;
    logic                   wlong_reg, wlong_next;
    logic [7:0]             flags_reg, flags_next;
    logic                   halt_reg, halt_next;

    logic [3:0]             cv;
    res_t                   cr [4];
    logic                   h;
    logic                   go_idle;
    logic [8:0]             fin;
    logic [OFFSET_BITS-1:0] nlen;
    logic [1:0]             k;
    res_t [2:0]             items;

    function automatic res_t mk(input logic [5:0] kind, input logic is_end,
                                input logic [OFFSET_BITS-1:0] b,
                                input logic [OFFSET_BITS-1:0] e,
                                input logic [2:0] err);
        res_t r;
        r.kind   = (err != E_NONE) ? 6'd0 : kind;
        r.is_end = is_end;
        r.span_b = SPAN_W'(b);
        r.span_e = SPAN_W'(e);
        r.is_err = err != E_NONE;
        r.err    = err;
        r.last   = 1'b0;
        r.done   = is_end || err != E_NONE;
        return r;
    endfunction

    // one-character result of a pending operator
    function automatic res_t single_of(input logic [3:0] m,
                                       input logic [OFFSET_BITS-1:0] s);
        logic [5:0] kd;
        logic [2:0] er;
        kd = K_PLUS;
        er = E_NONE;
        unique case (m)
            M_MINUS: kd = K_MINUS;
            M_SLASH: kd = K_SLASH;
            M_EQ:    kd = K_EQUAL;
            M_BANG:  er = E_UNEXP;
            M_LT:    kd = K_LESS;
            M_GT:    kd = K_GREATER;
            default: kd = K_PLUS;
        endcase
        return mk(kd, 1'b0, s, s + OFF_ONE, er);
    endfunction

    function automatic logic is_op_mode(input logic [3:0] m);
        return m == M_MINUS || m == M_SLASH || m == M_EQ || m == M_BANG
            || m == M_LT || m == M_GT;
    endfunction

    always_comb begin
        mode_next   = mode_reg;
        off_next    = off_reg;
        tstart_next = tstart_reg;
        word_next   = word_reg;
        wlen_next   = wlen_reg;
        wlong_next  = wlong_reg;
        flags_next  = flags_reg;
        halt_next   = halt_reg;
        cv          = 4'b0000;
        for (int i = 0; i < 4; i++) cr[i] = mk(K_PLUS, 1'b0, off_reg, off_reg, E_NONE);
        h           = halt_reg;
        go_idle     = 1'b0;
        fin         = finish_number(flags_reg);
        nlen        = OFFSET_BITS'(4);

        if (has_byte && !h) begin
            if (off_reg == OFF_MAX) begin
                mode_next = M_IDLE;
                cv[0] = 1'b1;
                cr[0] = mk(K_PLUS, 1'b0, off_reg, off_reg, E_TOOLONG);
                h = 1'b1;
            end else begin
                off_next = off_reg + OFF_ONE;
                unique case (mode_reg)
                    M_COMMENT: begin
                        if (text_byte == 8'h0D || text_byte == 8'h0A) mode_next = M_IDLE;
                    end
                    M_IDENT: begin
                        if (is_ident_start(text_byte) || is_digit(text_byte)) begin
                            if (wlen_reg < 3'd6) begin
                                word_next[8*wlen_reg +: 8] = text_byte;
                                wlen_next = wlen_reg + 3'd1;
                            end else begin
                                wlong_next = 1'b1;
                            end
                        end else begin
                            cv[0] = 1'b1;
                            cr[0] = mk(classify_word(word_reg, wlen_reg, wlong_reg), 1'b0,
                                       tstart_reg, off_reg, E_NONE);
                            go_idle = 1'b1;
                        end
                    end
                    M_NUMBER: begin
                        if (is_letter(text_byte) || is_digit(text_byte)
                                || text_byte == "_" || text_byte == ".") begin
                            flags_next = number_add(flags_reg, text_byte);
                        end else begin
                            cv[0] = 1'b1;
                            cr[0] = mk(fin[5:0], 1'b0, tstart_reg, off_reg, fin[8:6]);
                            go_idle = 1'b1;
                        end
                    end
                    M_MINUS, M_SLASH, M_EQ, M_BANG, M_LT, M_GT: begin
                        if ((mode_reg == M_MINUS && text_byte == ">")
                                || (mode_reg == M_SLASH && text_byte == "/")
                                || (mode_reg != M_MINUS && mode_reg != M_SLASH
                                    && text_byte == "=")) begin
                            mode_next = M_IDLE;
                            if (mode_reg == M_SLASH) begin
                                mode_next = M_COMMENT;
                            end else begin
                                cv[0] = 1'b1;
                                cr[0] = mk((mode_reg == M_MINUS) ? K_ARROW :
                                           (mode_reg == M_EQ)    ? K_EQ_EQ :
                                           (mode_reg == M_BANG)  ? K_BANG_EQ :
                                           (mode_reg == M_LT)    ? K_LESS_EQ : K_GREATER_EQ,
                                           1'b0, tstart_reg, off_next, E_NONE);
                            end
                        end else begin
                            cv[0] = 1'b1;
                            cr[0] = single_of(mode_reg, tstart_reg);
                            go_idle = 1'b1;
                        end
                    end
                    default: go_idle = 1'b1;
                endcase

                if (go_idle) begin
                    mode_next = M_IDLE;
                    if (cv[0] && cr[0].is_err) h = 1'b1;
                    if (!h) begin
                        case (text_byte)
                            8'h20, 8'h09, 8'h0D, 8'h0A: ;
                            "+": begin cv[1] = 1'b1; cr[1] = mk(K_PLUS, 1'b0, off_reg, off_next, E_NONE); end
                            "*": begin cv[1] = 1'b1; cr[1] = mk(K_STAR, 1'b0, off_reg, off_next, E_NONE); end
                            "%": begin cv[1] = 1'b1; cr[1] = mk(K_PERCENT, 1'b0, off_reg, off_next, E_NONE); end
                            "(": begin cv[1] = 1'b1; cr[1] = mk(K_LPAREN, 1'b0, off_reg, off_next, E_NONE); end
                            ")": begin cv[1] = 1'b1; cr[1] = mk(K_RPAREN, 1'b0, off_reg, off_next, E_NONE); end
                            "{": begin cv[1] = 1'b1; cr[1] = mk(K_LBRACE, 1'b0, off_reg, off_next, E_NONE); end
                            "}": begin cv[1] = 1'b1; cr[1] = mk(K_RBRACE, 1'b0, off_reg, off_next, E_NONE); end
                            ",": begin cv[1] = 1'b1; cr[1] = mk(K_COMMA, 1'b0, off_reg, off_next, E_NONE); end
                            ":": begin cv[1] = 1'b1; cr[1] = mk(K_COLON, 1'b0, off_reg, off_next, E_NONE); end
                            ";": begin cv[1] = 1'b1; cr[1] = mk(K_SEMI, 1'b0, off_reg, off_next, E_NONE); end
                            "-": begin tstart_next = off_reg; mode_next = M_MINUS; end
                            "/": begin tstart_next = off_reg; mode_next = M_SLASH; end
                            "=": begin tstart_next = off_reg; mode_next = M_EQ; end
                            "!": begin tstart_next = off_reg; mode_next = M_BANG; end
                            "<": begin tstart_next = off_reg; mode_next = M_LT; end
                            ">": begin tstart_next = off_reg; mode_next = M_GT; end
                            default: begin
                                tstart_next = off_reg;
                                if (is_ident_start(text_byte)) begin
                                    mode_next  = M_IDENT;
                                    word_next  = {40'd0, text_byte};
                                    wlen_next  = 3'd1;
                                    wlong_next = 1'b0;
                                end else if (is_digit(text_byte)) begin
                                    mode_next  = M_NUMBER;
                                    flags_next = 8'd0;
                                    flags_next[NF_FIRST_ZERO] = text_byte == "0";
                                end else if (text_byte >= 8'h80) begin
                                    nlen = (text_byte <= 8'hDF) ? OFFSET_BITS'(2) :
                                           (text_byte <= 8'hEF) ? OFFSET_BITS'(3) :
                                                                  OFFSET_BITS'(4);
                                    cv[1] = 1'b1;
                                    cr[1] = mk(K_PLUS, 1'b0, off_reg,
                                               ((OFF_MAX - off_reg) < nlen) ? OFF_MAX
                                                                            : off_reg + nlen,
                                               E_NONASCII);
                                    h = 1'b1;
                                end else begin
                                    cv[1] = 1'b1;
                                    cr[1] = mk(K_PLUS, 1'b0, off_reg, off_next, E_UNEXP);
                                    h = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
        end

        halt_next = h;
        if (end_of_source) begin
            if (!h) begin
                if (mode_next == M_IDENT) begin
                    cv[2] = 1'b1;
                    cr[2] = mk(classify_word(word_next, wlen_next, wlong_next), 1'b0,
                               tstart_next, off_next, E_NONE);
                end else if (mode_next == M_NUMBER) begin
                    fin = finish_number(flags_next);
                    cv[2] = 1'b1;
                    cr[2] = mk(fin[5:0], 1'b0, tstart_next, off_next, fin[8:6]);
                end else if (is_op_mode(mode_next)) begin
                    cv[2] = 1'b1;
                    cr[2] = single_of(mode_next, tstart_next);
                end
                if (cv[2] && cr[2].is_err) h = 1'b1;
                if (!h) begin
                    cv[3] = 1'b1;
                    cr[3] = mk(K_END, 1'b1, off_next, off_next, E_NONE);
                end
            end
            mode_next   = M_IDLE;
            off_next    = '0;
            tstart_next = '0;
            word_next   = '0;
            wlen_next   = 3'd0;
            wlong_next  = 1'b0;
            flags_next  = 8'd0;
            halt_next   = 1'b0;
        end
    end

    // keep the first three results in order, mark the final one
    always_comb begin
        k = 2'd0;
        items = '0;
        for (int i = 0; i < 4; i++) begin
            if (cv[i] && k != 2'd3) begin
                items[k] = cr[i];
                k = k + 2'd1;
            end
        end
        if (k != 2'd0) items[k - 2'd1].last = 1'b1;
        push.n    = accept ? k : 2'd0;
        push.item = items;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            off_reg    <= '0;
            tstart_reg <= '0;
            word_reg   <= '0;
            wlen_reg   <= 3'd0;
            wlong_reg  <= 1'b0;
            flags_reg  <= 8'd0;
            halt_reg   <= 1'b0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            off_reg    <= off_next;
            tstart_reg <= tstart_next;
            word_reg   <= word_next;
            wlen_reg   <= wlen_next;
            wlong_reg  <= wlong_next;
            flags_reg  <= flags_next;
            halt_reg   <= halt_next;
        end
    end

endmodule

// ----- hw/rtl/stt_out_queue.sv -----
// Four-entry result queue: takes up to three results a cycle, hands out one.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_out_queue
    import stt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  push_t  push,
    input  logic   pop,
    output res_t   head,
    output logic   head_valid,
    output qstat_t stat
);

    res_t       mem [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] count_reg, count_next;
    logic       do_pop;

    assign do_pop     = pop && count_reg != 3'd0;
    assign count_next = count_reg + 3'(push.n) - 3'(do_pop);
    assign head       = mem[rd_reg];
    assign head_valid = count_reg != 3'd0;
    assign stat.count = count_reg;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < push.n) mem[2'(wr_reg + 2'(i))] <= push.item[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= 2'd0;
            rd_reg    <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            wr_reg    <= wr_reg + push.n;
            rd_reg    <= rd_reg + 2'(do_pop);
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/source_text_tokenizer_top.sv -----
// Source text tokenizer: byte stream in, token stream out.
// Uses stt_pkg, stt_scan_core and stt_out_queue.
//
// Input channel s_*: one source byte per beat. s_tuser marks that the beat
// carries a byte, s_tlast closes the source (its byte, if any, is scanned first).
// Output channel m_*: one token, end token or error per beat; m_tlast marks the
// last result caused by an input beat.
// Throughput: one input beat per cycle while s_tready is high. The core scans
// each byte combinationally; its results (up to three) land in a four-entry
// queue and leave one per cycle while m_tready is high, from the cycle after
// the input beat on. s_tready is high while the queue holds at most one result,
// so a beat making more than one result slows the input until the queue drains.
// Reset clears the scanner to the start of a new source and empties the queue.
// When the receiver stalls, results wait in the queue and input stops once
// fewer than three slots are free.
// Offsets are OFFSET_BITS wide; spans report their low 24 bits.
`timescale 1ns / 1ps

module source_text_tokenizer_top
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [5:0] token_kind, [29:6] span_begin,
                                   // [53:30] span_end, [56:54] error_code
    output logic [2:0]  m_tuser,   // [0] is_end_token, [1] is_error, [2] source_done
    output logic        m_tlast    // last_of_run
);

    push_t  push;
    res_t   head;
    qstat_t qstat;
    logic   accept;

    assign s_tready = qstat.count <= 3'd1;
    assign accept   = s_tvalid && s_tready;

    stt_scan_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .text_byte     (s_tdata),
        .has_byte      (s_tuser[0]),
        .end_of_source (s_tlast),
        .push          (push)
    );

    stt_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_tready),
        .head       (head),
        .head_valid (m_tvalid),
        .stat       (qstat)
    );

    assign m_tdata = {7'd0, head.err, head.span_e, head.span_b, head.kind};
    assign m_tuser = {head.done, head.is_err, head.is_end};
    assign m_tlast = head.last;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.count <= 3'd4)
        else $error("result queue overfilled");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("source_done beat is not the last of its run");

    a_error_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[5:0] == 6'd0 && m_tdata[56:54] != E_NONE)
        else $error("error beat carries a token kind or no code");

endmodule
